// ===== rtl/tgc_pkg.sv =====
// Shared types, codes and constants for the touch gesture classifier.
`default_nettype none

package tgc_pkg;

  // Width of the tick counter, advanced by tick beats, and of all tick timestamps.
  localparam int TICK_WIDTH = 32;
  localparam int COORD_W    = 12;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Register reset values.
  localparam logic [15:0] DEBOUNCE_TICKS_RST     = 16'd5;
  localparam logic [11:0] CLICK_MAX_DISTANCE_RST = 12'd100;
  localparam logic [15:0] CLICK_MIN_TICKS_RST    = 16'd10;
  localparam logic [15:0] MOVE_MIN_TICKS_RST     = 16'd20;

  typedef logic [TICK_WIDTH-1:0] tick_t;
  typedef logic [COORD_W-1:0]    coord_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TICKS     = 2'd0,
    REG_CLICK_MAX_DISTANCE = 2'd1,
    REG_CLICK_MIN_TICKS    = 2'd2,
    REG_MOVE_MIN_TICKS     = 2'd3
  } reg_idx_t;

  // Item kinds carried by the action field.
  typedef enum logic {
    ACT_TICK   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    GEST_NONE  = 2'd0,
    GEST_CLICK = 2'd1,
    GEST_MOVE  = 2'd2
  } gesture_t;

  typedef enum logic [1:0] {
    PHASE_NONE  = 2'd0,
    PHASE_DOWN  = 2'd1,
    PHASE_PRESS = 2'd2,
    PHASE_UP    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    coord_t      click_max_distance;
    logic [15:0] click_min_ticks;
    logic [15:0] move_min_ticks;
  } cfg_t;

  typedef struct packed {
    action_t action;
    logic    touch_detected;
    coord_t  touch_x;
    coord_t  touch_y;
  } item_t;

  typedef struct packed {
    gesture_t gesture;
    phase_t   phase;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/touch_gesture_classifier_unit.sv =====
// Top level of the touch gesture classifier: input stage, core and result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries action, touch_detected, touch_x and
//   touch_y. A beat with action = 0 is a tick: it advances the internal tick counter
//   and gives no result. A beat with action = 1 is a touch sample and gives exactly
//   one result beat on the output channel (out_valid / out_stall) with gesture and
//   contact_phase.
//   A sample passes the input register and then the result register; all work for a
//   beat is done combinationally between them. Throughput: one beat per cycle, ticks
//   and samples alike, while no sample waits on a stalled receiver; the input register
//   and the result register each hold one beat.
//   When the receiver stalls, the result register holds its beat; a waiting sample in
//   the input register then stalls the input, while ticks still pass through.
//   Reset (rst, synchronous) empties both registers, clears the tick counter and all
//   touch state, and loads the register defaults. Configuration (cfg_wr_en, cfg_index,
//   cfg_data) is meant to change only while the block is idle.
`default_nettype none

module touch_gesture_classifier_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [tgc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tgc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            action,
  input  wire logic                            touch_detected,
  input  wire logic [tgc_pkg::COORD_W-1:0]     touch_x,
  input  wire logic [tgc_pkg::COORD_W-1:0]     touch_y,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           gesture,
  output logic [1:0]                           contact_phase
);
  import tgc_pkg::*;

  cfg_t    cfg;
  item_t   stage_item;
  logic    stage_vld;
  logic    stage_adv;
  logic    in_fire;
  logic    out_free;
  result_t core_res;
  result_t out_res;

  tgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The stage moves on unless it holds a sample and the result register is blocked.
  assign out_free  = !out_valid || !out_stall;
  assign stage_adv = stage_vld && (stage_item.action == ACT_TICK || out_free);
  assign in_stall  = stage_vld && !stage_adv;
  assign in_fire   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= 1'b0;
    end else begin
      stage_vld <= in_fire || (stage_vld && !stage_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_item <= '{action:         action_t'(action),
                      touch_detected: touch_detected,
                      touch_x:        touch_x,
                      touch_y:        touch_y};
    end
  end

  tgc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (stage_adv),
    .item    (stage_item),
    .cfg     (cfg),
    .res     (core_res)
  );

  // Result register: loaded by each sample, emptied when the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_adv && stage_item.action == ACT_SAMPLE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv && stage_item.action == ACT_SAMPLE) begin
      out_res <= core_res;
    end
  end

  assign gesture       = out_res.gesture;
  assign contact_phase = out_res.phase;

endmodule

`default_nettype wire

// ===== rtl/tgc_cfg_regs.sv =====
// Configuration register file of the touch gesture classifier.
`default_nettype none

module tgc_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [tgc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tgc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output tgc_pkg::cfg_t                        cfg
);
  import tgc_pkg::*;

  // Decode the index and write the selected register, masked to its width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= DEBOUNCE_TICKS_RST;
      cfg.click_max_distance <= CLICK_MAX_DISTANCE_RST;
      cfg.click_min_ticks    <= CLICK_MIN_TICKS_RST;
      cfg.move_min_ticks     <= MOVE_MIN_TICKS_RST;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE_TICKS:     cfg.debounce_ticks     <= cfg_data;
        REG_CLICK_MAX_DISTANCE: cfg.click_max_distance <= cfg_data[COORD_W-1:0];
        REG_CLICK_MIN_TICKS:    cfg.click_min_ticks    <= cfg_data;
        REG_MOVE_MIN_TICKS:     cfg.move_min_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tgc_core.sv =====
// Debounce, contact phase and gesture logic with its state registers.
`default_nettype none

module tgc_core (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step_en,
  input  wire tgc_pkg::item_t item,
  input  wire tgc_pkg::cfg_t  cfg,
  output tgc_pkg::result_t res
);
  import tgc_pkg::*;

  tick_t  tick_count, tick_count_next;
  tick_t  debounce_start, debounce_start_next;
  tick_t  press_time, press_time_next;
  logic   raw_prev_touch, raw_prev_touch_next;
  logic   filtered_touch, filtered_touch_next;
  coord_t filtered_x, filtered_x_next;
  coord_t filtered_y, filtered_y_next;
  coord_t press_x, press_x_next;
  coord_t press_y, press_y_next;

  tick_t  settle_age;
  tick_t  press_age;
  coord_t dist_x;
  coord_t dist_y;
  logic   is_sample;

  // Per-axis distance from the press point to the position held before this beat.
  assign dist_x = (filtered_x >= press_x) ? filtered_x - press_x : press_x - filtered_x;
  assign dist_y = (filtered_y >= press_y) ? filtered_y - press_y : press_y - filtered_y;
  // Press duration; the press time only changes on touch down, where it is not used.
  assign press_age = tick_count - press_time;
  assign is_sample = (item.action == ACT_SAMPLE);

  // Next state and the result of the current beat.
  always_comb begin
    tick_count_next     = tick_count;
    debounce_start_next = debounce_start;
    press_time_next     = press_time;
    raw_prev_touch_next = raw_prev_touch;
    filtered_touch_next = filtered_touch;
    filtered_x_next     = filtered_x;
    filtered_y_next     = filtered_y;
    press_x_next        = press_x;
    press_y_next        = press_y;
    res.gesture         = GEST_NONE;
    res.phase           = PHASE_NONE;
    settle_age          = tick_count - debounce_start;

    if (!is_sample) begin
      tick_count_next = tick_count + tick_t'(1);
    end else begin
      // A raw edge restarts the debounce window at the current tick.
      if (item.touch_detected != raw_prev_touch) begin
        debounce_start_next = tick_count;
        settle_age          = '0;
      end
      if (settle_age >= tick_t'(cfg.debounce_ticks)) begin
        filtered_touch_next = item.touch_detected;
        filtered_x_next     = item.touch_x;
        filtered_y_next     = item.touch_y;
      end
      raw_prev_touch_next = item.touch_detected;

      case ({filtered_touch, filtered_touch_next})
        2'b01: begin
          res.phase       = PHASE_DOWN;
          press_x_next    = filtered_x_next;
          press_y_next    = filtered_y_next;
          press_time_next = tick_count;
        end
        2'b11: begin
          res.phase = PHASE_PRESS;
          if (press_age > tick_t'(cfg.move_min_ticks)) begin
            res.gesture = GEST_MOVE;
          end
        end
        2'b10: begin
          res.phase = PHASE_UP;
          if (dist_x < cfg.click_max_distance && dist_y < cfg.click_max_distance &&
              press_age > tick_t'(cfg.click_min_ticks)) begin
            res.gesture = GEST_CLICK;
          end
        end
        default: res.phase = PHASE_NONE;
      endcase
    end
  end

  // State registers advance once per beat taken from the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      debounce_start <= '0;
      press_time     <= '0;
      raw_prev_touch <= 1'b0;
      filtered_touch <= 1'b0;
      filtered_x     <= '0;
      filtered_y     <= '0;
      press_x        <= '0;
      press_y        <= '0;
    end else if (step_en) begin
      tick_count     <= tick_count_next;
      debounce_start <= debounce_start_next;
      press_time     <= press_time_next;
      raw_prev_touch <= raw_prev_touch_next;
      filtered_touch <= filtered_touch_next;
      filtered_x     <= filtered_x_next;
      filtered_y     <= filtered_y_next;
      press_x        <= press_x_next;
      press_y        <= press_y_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tgc_checker.sv =====
// Port-level checker for the touch gesture classifier and its bind statement.
`default_nettype none

module tgc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] gesture,
  input wire logic [1:0] contact_phase
);
  import tgc_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(gesture) && $stable(contact_phase))
    else $error("result beat changed while stalled");

  // A click is only reported on release.
  a_click_on_up: assert property (@(posedge clk) disable iff (rst)
    out_valid && gesture == GEST_CLICK |-> contact_phase == PHASE_UP)
    else $error("click reported outside touch up");

  // A move is only reported while the contact is held.
  a_move_on_press: assert property (@(posedge clk) disable iff (rst)
    out_valid && gesture == GEST_MOVE |-> contact_phase == PHASE_PRESS)
    else $error("move reported outside pressing");

  // Touch down and no contact never carry a gesture, and no unused gesture code appears.
  a_quiet_phases: assert property (@(posedge clk) disable iff (rst)
    out_valid && (contact_phase == PHASE_DOWN || contact_phase == PHASE_NONE ||
                  gesture == 2'd3) |-> gesture == GEST_NONE)
    else $error("gesture on a phase that cannot have one");

  // The result register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind touch_gesture_classifier_unit tgc_checker u_tgc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .gesture       (gesture),
  .contact_phase (contact_phase)
);

`default_nettype wire

// ===== dv/tgc_gesture_check.sv =====
// Checker for the touch gesture classifier: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module tgc_gesture_check
  import tgc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  action,
  input  logic                  touch_detected,
  input  logic [COORD_W-1:0]    touch_x,
  input  logic [COORD_W-1:0]    touch_y,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [1:0]            gesture,
  input  logic [1:0]            contact_phase,
  output int                    mismatches,
  output int                    awaiting,
  output int                    results_seen,
  output int                    clicks_seen,
  output int                    moves_seen
);

  // Register copies.
  logic [15:0] bounce_gap;
  coord_t      tap_radius;
  logic [15:0] tap_min;
  logic [15:0] drag_min;

  // Touch tracking state.
  tick_t  now_ticks;
  tick_t  settle_from;
  tick_t  down_at;
  logic   last_raw;
  logic   held;
  coord_t held_x;
  coord_t held_y;
  coord_t down_x;
  coord_t down_y;

  result_t expected_gestures[$];

  function automatic coord_t coord_gap(coord_t a, coord_t b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Debounce one sample, update the contact state and name the gesture it gives.
  function automatic result_t classify_sample(logic raw, coord_t sx, coord_t sy);
    result_t r;
    logic    was_held;
    coord_t  prev_x;
    coord_t  prev_y;
    tick_t   elapsed;
    r.gesture = GEST_NONE;
    r.phase   = PHASE_NONE;
    was_held  = held;
    prev_x    = held_x;
    prev_y    = held_y;
    if (raw != last_raw) begin
      settle_from = now_ticks;
    end
    elapsed = now_ticks - settle_from;
    if (elapsed >= tick_t'(bounce_gap)) begin
      held   = raw;
      held_x = sx;
      held_y = sy;
    end
    elapsed = now_ticks - down_at;
    case ({was_held, held})
      2'b01: begin
        r.phase = PHASE_DOWN;
        down_x  = held_x;
        down_y  = held_y;
        down_at = now_ticks;
      end
      2'b11: begin
        r.phase = PHASE_PRESS;
        if (elapsed > tick_t'(drag_min)) begin
          r.gesture = GEST_MOVE;
        end
      end
      2'b10: begin
        // The release is judged on the position held before this sample.
        r.phase = PHASE_UP;
        if (coord_gap(prev_x, down_x) < tap_radius && coord_gap(prev_y, down_y) < tap_radius
            && elapsed > tick_t'(tap_min)) begin
          r.gesture = GEST_CLICK;
        end
      end
      default: ;
    endcase
    last_raw = raw;
    return r;
  endfunction

  // Result beats are compared before the input beat of the same edge is predicted.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      bounce_gap   = DEBOUNCE_TICKS_RST;
      tap_radius   = CLICK_MAX_DISTANCE_RST;
      tap_min      = CLICK_MIN_TICKS_RST;
      drag_min     = MOVE_MIN_TICKS_RST;
      now_ticks    = '0;
      settle_from  = '0;
      down_at      = '0;
      last_raw     = 1'b0;
      held         = 1'b0;
      held_x       = '0;
      held_y       = '0;
      down_x       = '0;
      down_y       = '0;
      mismatches   = 0;
      results_seen = 0;
      clicks_seen  = 0;
      moves_seen   = 0;
      expected_gestures.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_gestures.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected result beat: gesture %0d, phase %0d", gesture,
                     contact_phase);
          end
        end else begin
          want = expected_gestures.pop_front();
          if (gesture !== want.gesture || contact_phase !== want.phase) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Result %0d differs: gesture exp %0d got %0d, phase exp %0d got %0d",
                       results_seen, want.gesture, gesture, want.phase, contact_phase);
            end
          end
          if (want.gesture == GEST_CLICK) clicks_seen++;
          if (want.gesture == GEST_MOVE) moves_seen++;
        end
      end

      if (cfg_wr_en) begin
        case (reg_idx_t'(cfg_index))
          REG_DEBOUNCE_TICKS:     bounce_gap = cfg_data;
          REG_CLICK_MAX_DISTANCE: tap_radius = cfg_data[COORD_W-1:0];
          REG_CLICK_MIN_TICKS:    tap_min    = cfg_data;
          REG_MOVE_MIN_TICKS:     drag_min   = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (action == ACT_TICK) begin
          now_ticks = now_ticks + 1'b1;
        end else begin
          expected_gestures.push_back(classify_sample(touch_detected, touch_x, touch_y));
        end
      end
    end
    awaiting = expected_gestures.size();
  end

endmodule

// ===== dv/tb_touch_gesture_classifier_unit.sv =====
// Testbench top for the touch gesture classifier: stimulus, receiver, watchdog and verdict.
`timescale 1ns / 100ps

module tb_touch_gesture_classifier_unit;
  import tgc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int COORD_MAX      = (1 << COORD_W) - 1;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  action;
  logic                  touch_detected;
  coord_t                touch_x;
  coord_t                touch_y;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            gesture;
  logic [1:0]            contact_phase;

  int mismatches;
  int awaiting;
  int results_seen;
  int clicks_seen;
  int moves_seen;
  int items_sent;
  int settings_used;
  int idle_cycles;
  int cur_bounce;
  int cur_drag;
  bit burst_mode;
  bit hold_req;

  touch_gesture_classifier_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .touch_detected (touch_detected),
    .touch_x        (touch_x),
    .touch_y        (touch_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .gesture        (gesture),
    .contact_phase  (contact_phase)
  );

  tgc_gesture_check u_gesture_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .touch_detected (touch_detected),
    .touch_x        (touch_x),
    .touch_y        (touch_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .gesture        (gesture),
    .contact_phase  (contact_phase),
    .mismatches     (mismatches),
    .awaiting       (awaiting),
    .results_seen   (results_seen),
    .clicks_seen    (clicks_seen),
    .moves_seen     (moves_seen)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d results still expected",
               idle_cycles, awaiting);
      $display("touch_gesture_classifier_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: a random stall before each result beat, and one long hold on request.
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold     = LONG_HOLD;
      end else begin
        hold = burst_mode ? 0 : $urandom_range(0, 8);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Offer one beat after a random gap and hold it until it is taken.
  task automatic push_item(action_t act, logic touch, coord_t x, coord_t y);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    action         <= act;
    touch_detected <= touch;
    touch_x        <= x;
    touch_y        <= y;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // Tick beats carry random filler in the fields the block ignores.
  task automatic pass_ticks(int n);
    repeat (n) push_item(ACT_TICK, 1'($urandom_range(0, 1)), coord_t'($urandom),
                         coord_t'($urandom));
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return coord_t'(COORD_MAX);
      default: return coord_t'($urandom_range(0, COORD_MAX));
    endcase
  endfunction

  function automatic coord_t near(coord_t c, int spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    else if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  // Ticks to wait out the debounce, capped at 12, sometimes a little short of it.
  function automatic int settle_ticks();
    int b;
    b = (cur_bounce > 12) ? 12 : cur_bounce;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, b);
    return b + $urandom_range(0, 2);
  endfunction

  // Drop valid, wait for every expected result, then let a trailing tick drain.
  task automatic quiesce();
    in_valid <= 1'b0;
    wait (awaiting == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all four registers back to back while the block is idle.
  task automatic load_settings(logic [15:0] bounce, logic [15:0] radius,
                               logic [15:0] tap, logic [15:0] drag);
    reg_idx_t    order [4];
    logic [15:0] vals [4];
    order = '{REG_DEBOUNCE_TICKS, REG_CLICK_MAX_DISTANCE, REG_CLICK_MIN_TICKS,
              REG_MOVE_MIN_TICKS};
    vals  = '{bounce, radius, tap, drag};
    quiesce();
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      @(negedge clk);
    end
    cfg_wr_en  <= 1'b0;
    cur_bounce = bounce;
    cur_drag   = drag;
    settings_used++;
  endtask

  // Mostly whole press-hold-release gestures with random content, the rest noise.
  task automatic run_gestures(int budget);
    int     stop;
    int     spread;
    int     span;
    int     n;
    coord_t px;
    coord_t py;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      burst_mode = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) begin
        px = pick_coord();
        py = pick_coord();
        case ($urandom_range(0, 3))
          0:       spread = 0;
          1:       spread = $urandom_range(0, 400);
          default: spread = $urandom_range(0, 120);
        endcase
        // Touch down, with an occasional contact bounce.
        push_item(ACT_SAMPLE, 1'b1, px, py);
        if ($urandom_range(0, 4) == 0) begin
          pass_ticks(1);
          push_item(ACT_SAMPLE, 1'b0, px, py);
          push_item(ACT_SAMPLE, 1'b1, px, py);
        end
        pass_ticks(settle_ticks());
        // Hold with drifting position, interleaved with ticks.
        span = (cur_drag > 40) ? 40 : cur_drag;
        n    = $urandom_range(0, 2 * span + 6);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0) pass_ticks(1);
          else push_item(ACT_SAMPLE, 1'b1, near(px, spread), near(py, spread));
        end
        // Release, with an occasional bounce on the way up.
        push_item(ACT_SAMPLE, 1'b0, near(px, spread), near(py, spread));
        if ($urandom_range(0, 4) == 0) begin
          push_item(ACT_SAMPLE, 1'b1, near(px, spread), near(py, spread));
          push_item(ACT_SAMPLE, 1'b0, near(px, spread), near(py, spread));
        end
        pass_ticks(settle_ticks());
        push_item(ACT_SAMPLE, 1'b0, pick_coord(), pick_coord());
      end else begin
        repeat ($urandom_range(1, 6)) begin
          push_item(action_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    pick_coord(), pick_coord());
        end
      end
    end
    burst_mode = 1'b0;
  endtask

  // Main sequence.
  initial begin
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_index      = REG_DEBOUNCE_TICKS;
    cfg_data       = '0;
    in_valid       = 1'b0;
    action         = ACT_TICK;
    touch_detected = 1'b0;
    touch_x        = '0;
    touch_y        = '0;
    items_sent     = 0;
    settings_used  = 1;
    burst_mode     = 1'b0;
    hold_req       = 1'b0;
    cur_bounce     = DEBOUNCE_TICKS_RST;
    cur_drag       = MOVE_MIN_TICKS_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed gesture at the reset settings: idle, down, pressing, up with a click,
    // and the release judged on the position held before the lift-off sample.
    push_item(ACT_SAMPLE, 1'b0, coord_t'(COORD_MAX), coord_t'(COORD_MAX));
    push_item(ACT_SAMPLE, 1'b1, coord_t'(COORD_MAX), '0);
    pass_ticks(5);
    push_item(ACT_SAMPLE, 1'b1, coord_t'(COORD_MAX), '0);
    pass_ticks(11);
    push_item(ACT_SAMPLE, 1'b1, 12'hF9C, 12'h032);
    push_item(ACT_SAMPLE, 1'b0, '0, coord_t'(COORD_MAX));
    pass_ticks(5);
    push_item(ACT_SAMPLE, 1'b0, '0, coord_t'(COORD_MAX));

    // Reset settings, with one long receiver hold while samples keep coming.
    run_gestures(60);
    hold_req = 1'b1;
    run_gestures(300);

    // No debounce, smallest nonzero distance limit, zero durations.
    load_settings(16'd0, 16'd1, 16'd0, 16'd0);
    run_gestures(270);

    // Distance limit masked to zero, longest durations.
    load_settings(16'd3, 16'hF000, 16'hFFFF, 16'hFFFF);
    run_gestures(220);

    // Longest debounce, widest distance limit after masking.
    load_settings(16'hFFFF, 16'hFFFF, 16'h8000, 16'h0001);
    run_gestures(80);

    // Random moderate settings.
    repeat (3) begin
      load_settings(16'($urandom_range(0, 6)), 16'($urandom_range(1, 300)),
                    16'($urandom_range(0, 15)), 16'($urandom_range(0, 30)));
      run_gestures(150);
    end

    quiesce();
    $display("Sent %0d beats under %0d register settings; checked %0d results.",
             items_sent, settings_used, results_seen);
    $display("Predicted gestures seen: %0d clicks, %0d moves; %0d mismatches.",
             clicks_seen, moves_seen, mismatches);
    if (mismatches == 0) begin
      $display("touch_gesture_classifier_unit: match");
    end else begin
      $display("touch_gesture_classifier_unit: mismatch");
    end
    $finish;
  end

endmodule
